[rtl/core/nm3_pkg.sv]
// Shared types and widths for the 3x3 normal matrix block.
package nm3_pkg;

    localparam int ELEM_W = 16;
    localparam int COF_W  = 33;   // |C| <= 2^31, signed
    localparam int DET_W  = 50;   // |D| < 2^48, signed, one guard bit
    localparam int CM_W   = 32;   // cofactor magnitude
    localparam int DM_W   = 48;   // determinant magnitude
    localparam int Q_W    = 33;   // quotient bits kept before clamping
    localparam int OUT_W  = 32;
    localparam int NUM_EL = 9;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [OUT_W-1:0]         res_t;

    // One classified item handed from the front to the back part
    typedef struct packed {
        logic [NUM_EL-1:0][CM_W-1:0] cmag;
        logic [NUM_EL-1:0]           neg;
        logic [DM_W-1:0]             dmag;
        logic                        singular;
    } work_t;

endpackage

[rtl/core/nm3_front.sv]
// Front part: cofactors, determinant and sign/magnitude split, pipelined.
module nm3_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  nm3_pkg::elem_t [8:0]         in_elem,
    output logic                         out_valid,
    output nm3_pkg::work_t               out_work
);
    import nm3_pkg::*;

    // Stage 1: products of the 2x2 minors
    logic        s1_valid_reg;
    elem_t [2:0] s1_a_reg;
    logic signed [31:0] s1_p_reg [0:17];
    logic signed [31:0] p_next [0:17];

    // a index = c*3+r
    always_comb
    begin
        p_next[0]  = 32'(in_elem[4] * in_elem[8]); p_next[1]  = 32'(in_elem[7] * in_elem[5]);
        p_next[2]  = 32'(in_elem[7] * in_elem[2]); p_next[3]  = 32'(in_elem[8] * in_elem[1]);
        p_next[4]  = 32'(in_elem[1] * in_elem[5]); p_next[5]  = 32'(in_elem[4] * in_elem[2]);
        p_next[6]  = 32'(in_elem[6] * in_elem[5]); p_next[7]  = 32'(in_elem[3] * in_elem[8]);
        p_next[8]  = 32'(in_elem[0] * in_elem[8]); p_next[9]  = 32'(in_elem[6] * in_elem[2]);
        p_next[10] = 32'(in_elem[3] * in_elem[2]); p_next[11] = 32'(in_elem[5] * in_elem[0]);
        p_next[12] = 32'(in_elem[3] * in_elem[7]); p_next[13] = 32'(in_elem[4] * in_elem[6]);
        p_next[14] = 32'(in_elem[6] * in_elem[1]); p_next[15] = 32'(in_elem[0] * in_elem[7]);
        p_next[16] = 32'(in_elem[0] * in_elem[4]); p_next[17] = 32'(in_elem[1] * in_elem[3]);
    end

    // Stage 2: cofactors
    logic        s2_valid_reg;
    elem_t [2:0] s2_a_reg;
    cof_t [8:0]  s2_cof_reg;
    // Stage 3: column-0 terms of the determinant
    logic        s3_valid_reg;
    cof_t [8:0]  s3_cof_reg;
    det_t [2:0]  s3_t_reg;
    // Stage 4: determinant
    logic        s4_valid_reg;
    cof_t [8:0]  s4_cof_reg;
    det_t        s4_det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg <= in_elem[2:0];
        for (int i = 0; i < 18; i++)
            s1_p_reg[i] <= p_next[i];
        s2_a_reg <= {s1_a_reg[2], s1_a_reg[1], s1_a_reg[0]};
        for (int i = 0; i < 9; i++)
            s2_cof_reg[i] <= cof_t'(s1_p_reg[2*i]) - cof_t'(s1_p_reg[2*i+1]);
        s3_cof_reg <= s2_cof_reg;
        // Column-0 element (0,r) times its cofactor, which sits at slot 3*r
        for (int i = 0; i < 3; i++)
            s3_t_reg[i] <= det_t'(s2_a_reg[i] * s2_cof_reg[3*i]);
        s4_cof_reg <= s3_cof_reg;
        s4_det_reg <= s3_t_reg[0] + s3_t_reg[1] + s3_t_reg[2];
    end

    // Cofactor order above: (0,0),(1,0),(2,0),(0,1),(1,1),(2,1),(0,2),(1,2),(2,2)
    // Remap into element order c*3+r, and split sign from magnitude
    localparam int MAP [0:8] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
    logic det_neg;
    always_comb
    begin
        det_neg = s4_det_reg[DET_W-1];
        out_valid = s4_valid_reg;
        out_work.dmag = DM_W'(det_neg ? -s4_det_reg : s4_det_reg);
        out_work.singular = (s4_det_reg == '0);
        for (int e = 0; e < 9; e++)
        begin
            out_work.cmag[e] = CM_W'(s4_cof_reg[MAP[e]][COF_W-1] ?
                -s4_cof_reg[MAP[e]] : s4_cof_reg[MAP[e]]);
            out_work.neg[e] = (s4_cof_reg[MAP[e]][COF_W-1] != det_neg)
                && (s4_cof_reg[MAP[e]] != '0);
        end
    end

endmodule

[rtl/core/nm3_queue.sv]
// Short queue that parts the front from the back.
module nm3_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nm3_pkg::work_t push_data,
    output logic           pop_valid,
    output nm3_pkg::work_t pop_data
);
    import nm3_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_t          mem_reg [0:DEPTH-1];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [PW:0]    cnt_reg;

    // The back part never stalls, so the queue drains every cycle it holds an item
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop_valid)
                rd_reg <= (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop_valid);
        end
    end

endmodule

[rtl/core/nm3_back.sv]
// Back part: nine pipelined restoring dividers, rounding and clamping.
module nm3_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  nm3_pkg::work_t                in_work,
    output logic                          out_valid,
    output nm3_pkg::res_t [8:0]           out_res,
    output logic                          out_singular,
    output logic                          out_saturated
);
    import nm3_pkg::*;

    // Dividend N = cm*2^31 + dm (64 bits), divisor 2*dm (49 bits).
    // Quotient beyond Q_W bits only matters as "saturate"; detect that first.
    localparam int N_W  = CM_W + 31 + 1;
    localparam int DV_W = DM_W + 1;
    localparam int NSTG = Q_W;

    logic [N_W-1:0]  n_in [0:8];
    logic [DV_W-1:0] dv_in;
    logic [8:0]      big_in;

    always_comb
    begin
        dv_in = {in_work.dmag, 1'b0};
        for (int e = 0; e < 9; e++)
        begin
            n_in[e] = {1'b0, in_work.cmag[e], 31'd0} + N_W'(in_work.dmag);
            // quotient >= 2^Q_W exactly when N >= dv * 2^Q_W
            big_in[e] = (n_in[e] >> Q_W) >= N_W'(dv_in);
        end
    end

    // One quotient bit per stage, MSB first
    logic                  vld_reg  [0:NSTG];
    logic                  sng_reg  [0:NSTG];
    logic [DV_W-1:0]       dv_reg   [0:NSTG];
    logic [8:0]            neg_reg  [0:NSTG];
    logic [8:0]            big_reg  [0:NSTG];
    logic [N_W-1:0]        rem_reg  [0:8][0:NSTG];
    logic [Q_W-1:0]        q_reg    [0:8][0:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int s = 0; s <= NSTG; s++)
                vld_reg[s] <= 1'b0;
        else
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= NSTG; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sng_reg[0] <= in_work.singular;
        dv_reg[0]  <= dv_in;
        neg_reg[0] <= in_work.neg;
        big_reg[0] <= big_in;
        for (int e = 0; e < 9; e++)
        begin
            rem_reg[e][0] <= n_in[e];
            q_reg[e][0]   <= '0;
        end
        for (int s = 1; s <= NSTG; s++)
        begin
            sng_reg[s] <= sng_reg[s-1];
            dv_reg[s]  <= dv_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            big_reg[s] <= big_reg[s-1];
            for (int e = 0; e < 9; e++)
            begin
                if (!big_reg[s-1][e] &&
                    (rem_reg[e][s-1] >> (Q_W-s)) >= N_W'(dv_reg[s-1]))
                begin
                    rem_reg[e][s] <= rem_reg[e][s-1] - (N_W'(dv_reg[s-1]) << (Q_W-s));
                    q_reg[e][s]   <= q_reg[e][s-1] | (Q_W'(1) << (Q_W-s));
                end
                else
                begin
                    rem_reg[e][s] <= rem_reg[e][s-1];
                    q_reg[e][s]   <= q_reg[e][s-1];
                end
            end
        end
    end

    // Sign, clamp and zero on singular, then register the result
    logic                out_valid_reg, sing_reg, sat_reg;
    res_t [8:0]          res_reg;
    res_t [8:0]          res_next;
    logic [8:0]          sat_e;

    always_comb
    begin
        for (int e = 0; e < 9; e++)
        begin
            sat_e[e] = 1'b0;
            if (sng_reg[NSTG])
                res_next[e] = '0;
            else if (neg_reg[NSTG][e])
            begin
                if (big_reg[NSTG][e] || q_reg[e][NSTG] > Q_W'(33'h080000000))
                begin
                    sat_e[e] = 1'b1;
                    res_next[e] = 32'h80000000;
                end
                else
                    res_next[e] = OUT_W'(-q_reg[e][NSTG]);
            end
            else if (big_reg[NSTG][e] || q_reg[e][NSTG] > Q_W'(33'h07FFFFFFF))
            begin
                sat_e[e] = 1'b1;
                res_next[e] = 32'h7FFFFFFF;
            end
            else
                res_next[e] = OUT_W'(q_reg[e][NSTG]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        sing_reg <= sng_reg[NSTG];
        sat_reg  <= |sat_e;
    end

    assign out_valid     = out_valid_reg;
    assign out_res       = res_reg;
    assign out_singular  = sing_reg;
    assign out_saturated = sat_reg;

endmodule

[rtl/core/normal_matrix_3x3.sv]
// Top level of the 3x3 inverse-transpose (normal matrix) block.
// A matrix is taken at any edge where start is high; busy stays low, so one item
// enters every clock. Each result appears on the out ports with done high for
// exactly one cycle. Between start and done lie the cofactor and determinant
// multiplier stages, one queue slot, a pipelined divider (an input register,
// then 33 restoring stages of one quotient bit each), and an output register.
// Results cannot be held off.
module normal_matrix_3x3 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [15:0]    in_c0_r0,
    input  logic signed [15:0]    in_c0_r1,
    input  logic signed [15:0]    in_c0_r2,
    input  logic signed [15:0]    in_c1_r0,
    input  logic signed [15:0]    in_c1_r1,
    input  logic signed [15:0]    in_c1_r2,
    input  logic signed [15:0]    in_c2_r0,
    input  logic signed [15:0]    in_c2_r1,
    input  logic signed [15:0]    in_c2_r2,
    output logic                  done,
    output logic signed [31:0]    out_c0_r0,
    output logic signed [31:0]    out_c0_r1,
    output logic signed [31:0]    out_c0_r2,
    output logic signed [31:0]    out_c1_r0,
    output logic signed [31:0]    out_c1_r1,
    output logic signed [31:0]    out_c1_r2,
    output logic signed [31:0]    out_c2_r0,
    output logic signed [31:0]    out_c2_r1,
    output logic signed [31:0]    out_c2_r2,
    output logic                  singular,
    output logic                  saturated
);
    import nm3_pkg::*;

    elem_t [8:0] elem;
    logic        f_valid, q_valid;
    work_t       f_work, q_work;
    res_t [8:0]  res;

    assign busy = 1'b0;
    assign elem = {in_c2_r2, in_c2_r1, in_c2_r0, in_c1_r2, in_c1_r1, in_c1_r0,
                   in_c0_r2, in_c0_r1, in_c0_r0};

    nm3_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .in_elem(elem),
        .out_valid(f_valid), .out_work(f_work)
    );

    nm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_work),
        .pop_valid(q_valid), .pop_data(q_work)
    );

    nm3_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_work(q_work),
        .out_valid(done), .out_res(res), .out_singular(singular),
        .out_saturated(saturated)
    );

    assign out_c0_r0 = res[0];
    assign out_c0_r1 = res[1];
    assign out_c0_r2 = res[2];
    assign out_c1_r0 = res[3];
    assign out_c1_r1 = res[4];
    assign out_c1_r2 = res[5];
    assign out_c2_r0 = res[6];
    assign out_c2_r1 = res[7];
    assign out_c2_r2 = res[8];

endmodule

[rtl/core/nm3_checker.sv]
// Port-level checker for the normal matrix block, with its bind.
module nm3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        singular,
    input logic        saturated,
    input logic [31:0] out_c0_r0,
    input logic [31:0] out_c1_r1,
    input logic [31:0] out_c2_r2
);
    // A singular result carries zeros and no saturation
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && singular |-> !saturated && out_c0_r0 == '0 && out_c1_r1 == '0
        && out_c2_r2 == '0) else $error("singular result not cleared");

    // Each accepted item is followed by its result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##40 done) else $error("result missing");

    // No result without an earlier accepted item
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 40)) else $error("spurious result");

    // The block never stalls its input
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");
endmodule

bind normal_matrix_3x3 nm3_checker u_nm3_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .singular(singular), .saturated(saturated), .out_c0_r0(out_c0_r0),
    .out_c1_r1(out_c1_r1), .out_c2_r2(out_c2_r2)
);
